@@ src/stack_bytecode_executor_unit_macros.svh @@
// assertion helper macros for the stack bytecode executor
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef STACK_BYTECODE_EXECUTOR_UNIT_MACROS_SVH
`define STACK_BYTECODE_EXECUTOR_UNIT_MACROS_SVH

// same-cycle implication, checks off while reset is asserted
`define SBE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checks off while reset is asserted
`define SBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sbe_pkg.sv @@
// shared types and constants of the stack bytecode executor
// no dependencies; imported by sbe_muldiv and stack_bytecode_executor_unit
`default_nettype none

package sbe_pkg;

    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int ACT_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int DEPTH_OUT_W = 9;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 5;

    // opcodes
    localparam logic [ACT_W-1:0] OP_CONST = 4'd0;
    localparam logic [ACT_W-1:0] OP_ADD   = 4'd1;
    localparam logic [ACT_W-1:0] OP_SUB   = 4'd2;
    localparam logic [ACT_W-1:0] OP_MUL   = 4'd3;
    localparam logic [ACT_W-1:0] OP_DIV   = 4'd4;
    localparam logic [ACT_W-1:0] OP_NEG   = 4'd5;
    localparam logic [ACT_W-1:0] OP_POP   = 4'd6;
    localparam logic [ACT_W-1:0] OP_SHOW  = 4'd7;
    localparam logic [ACT_W-1:0] OP_GT    = 4'd8;
    localparam logic [ACT_W-1:0] OP_RET   = 4'd9;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_HALTED    = 3'd1;
    localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_DIVZERO   = 3'd4;
    localparam logic [STATUS_W-1:0] STS_UNKNOWN   = 3'd5;

    // one stack entry: tag above payload
    typedef struct packed {
        logic              is_bool;
        logic [WORD_W-1:0] payload;
    } t_entry;

    // request to the multiply / divide unit
    typedef struct packed {
        logic              start;
        logic              is_div;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_md_req;

    // response from the multiply / divide unit
    typedef struct packed {
        logic              busy;
        logic [WORD_W-1:0] result;
    } t_md_rsp;

endpackage

`default_nettype wire

@@ src/sbe_muldiv.sv @@
// multi-cycle 64-bit multiply (low half) and signed divide for the executor
// depends on sbe_pkg; multiply uses one 32x32 multiplier, divide is radix-2
`default_nettype none

module sbe_muldiv (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  sbe_pkg::t_md_req      i_req,
    output sbe_pkg::t_md_rsp      o_rsp
);
    import sbe_pkg::*;

    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_MUL  = 2'd1;
    localparam logic [1:0] MD_DIV  = 2'd2;
    localparam logic [1:0] MD_FIX  = 2'd3;

    localparam int CNT_W = $clog2(WORD_W);

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_prod;
    logic [WORD_W-1:0] r_acc;
    logic              r_neg;

    logic [HALF_W-1:0] w_mul_x;
    logic [HALF_W-1:0] w_mul_y;
    logic [WORD_W-1:0] w_prod;
    logic [WORD_W:0]   w_rem_sh;
    logic [WORD_W:0]   w_diff;
    logic              w_ge;

    // partial products: lo*lo, lo*hi, hi*lo
    assign w_mul_x = (r_cnt == CNT_W'(2)) ? r_a[WORD_W-1:HALF_W] : r_a[HALF_W-1:0];
    assign w_mul_y = (r_cnt == CNT_W'(1)) ? r_b[WORD_W-1:HALF_W] : r_b[HALF_W-1:0];
    assign w_prod  = WORD_W'(w_mul_x) * WORD_W'(w_mul_y);

    assign w_rem_sh = {r_rem, r_a[WORD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_b};
    assign w_ge     = !w_diff[WORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                MD_IDLE: begin
                    if (i_req.start) begin
                        r_cnt   <= '0;
                        r_state <= i_req.is_div ? MD_DIV : MD_MUL;
                    end
                end
                MD_MUL: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(3)) begin
                        r_state <= MD_IDLE;
                    end
                end
                MD_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(WORD_W - 1)) begin
                        r_state <= MD_FIX;
                    end
                end
                MD_FIX: begin
                    r_state <= MD_IDLE;
                end
                default: r_state <= MD_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            MD_IDLE: begin
                if (i_req.start) begin
                    if (i_req.is_div) begin
                        // magnitudes; the minimum value stays 2^63 as unsigned
                        r_a   <= i_req.a[WORD_W-1] ? (WORD_W'(0) - i_req.a) : i_req.a;
                        r_b   <= i_req.b[WORD_W-1] ? (WORD_W'(0) - i_req.b) : i_req.b;
                        r_rem <= '0;
                        r_neg <= i_req.a[WORD_W-1] ^ i_req.b[WORD_W-1];
                    end else begin
                        r_a <= i_req.a;
                        r_b <= i_req.b;
                    end
                end
            end
            MD_MUL: begin
                r_prod <= w_prod;
                if (r_cnt == CNT_W'(1)) begin
                    r_acc <= r_prod;
                end else if (r_cnt != CNT_W'(0)) begin
                    r_acc <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
                end
            end
            MD_DIV: begin
                r_rem <= w_ge ? w_diff[WORD_W-1:0] : w_rem_sh[WORD_W-1:0];
                r_a   <= {r_a[WORD_W-2:0], w_ge};
            end
            MD_FIX: begin
                r_acc <= r_neg ? (WORD_W'(0) - r_a) : r_a;
            end
            default: ;
        endcase
    end

    assign o_rsp.busy   = (r_state != MD_IDLE);
    assign o_rsp.result = r_acc;

endmodule

`default_nettype wire

@@ src/stack_bytecode_executor_unit.sv @@
// stack bytecode executor: top level with the value stack memory and sequencer
// depends on sbe_pkg, sbe_muldiv and stack_bytecode_executor_unit_macros.svh
//
// one instruction per input beat on s_axis, one result beat per instruction
// on m_axis. the stack lives in a one-port-write, one-port-read synchronous
// memory; the top entry is also kept in a register so one read per
// instruction (the entry below the top) is enough.
// timing: the read is issued on the accept edge; once the output is free, the
// block reads, modifies and writes back and loads the output register, which
// drives the result beat; mul and div first wait in a wait state for the unit.
// the input is ready again right after the output load, so a new instruction
// is taken only after the last one has loaded its result. mul runs through the
// 32x32 multiplier, div through the bit-per-cycle divider.
// the output register holds a result while m_axis_tready is low; the next
// instruction is still accepted and its operand read, but it waits in the
// execute state, before any stack write, until the held beat is taken.
// reset clears the stack pointer and the halted flag; the stack memory is not
// cleared and needs no clearing pass. after a return instruction every beat
// reports halted until the next reset.
`default_nettype none

module stack_bytecode_executor_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [63:0] constant_value
    input  wire logic [sbe_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [3:0] action, [4] constant_is_bool
    input  wire logic [sbe_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [63:0] show_value, [72:64] depth_after, [79:73] zero
    output logic [sbe_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // [2:0] status, [3] print_valid, [4] print_is_bool
    output logic [sbe_pkg::M_TUSER_W-1:0]        m_axis_tuser
);
    import sbe_pkg::*;

    `include "stack_bytecode_executor_unit_macros.svh"

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    // stack memory
    t_entry r_mem [STACK_DEPTH];
    t_entry r_rd_data;

    logic [1:0]        r_state, n_state;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic              r_halted, n_halted;
    t_entry            r_tos, n_tos;

    // instruction being executed
    logic [ACT_W-1:0]  r_act;
    logic [WORD_W-1:0] r_cval;
    logic              r_cbool;

    // output register
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic                  r_out_pvalid;
    logic [WORD_W-1:0]     r_out_pval;
    logic                  r_out_pbool;
    logic [DEPTH_OUT_W-1:0] r_out_depth;

    logic              w_accept;
    logic              w_out_free;
    logic              w_mem_re;
    logic [AW-1:0]     w_rd_addr;
    logic              w_mem_we;
    logic [AW-1:0]     w_wr_addr;
    t_entry            w_wr_data;
    logic              w_fin;
    logic [STATUS_W-1:0] w_fin_status;
    logic              w_fin_print;
    logic [AW-1:0]     w_addr_top;
    logic [AW-1:0]     w_addr_nos;
    logic              w_lt1;
    logic              w_lt2;
    logic [WORD_W-1:0] w_a;
    logic [WORD_W-1:0] w_b;
    logic [WORD_W-1:0] w_alu;
    logic              w_md_start;
    t_md_req           w_md_req;
    t_md_rsp           w_md_rsp;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_addr_top = AW'(r_sp - SP_W'(1));
    assign w_addr_nos = AW'(r_sp - SP_W'(2));
    assign w_lt1      = (r_sp < SP_W'(1));
    assign w_lt2      = (r_sp < SP_W'(2));

    // entry below the top is fetched at accept
    assign w_mem_re  = w_accept && !w_lt2;
    assign w_rd_addr = w_addr_nos;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign w_a = r_rd_data.payload;
    assign w_b = r_tos.payload;

    always_comb begin
        unique case (r_act)
            OP_ADD:  w_alu = w_a + w_b;
            OP_SUB:  w_alu = w_a - w_b;
            default: w_alu = {{(WORD_W-1){1'b0}}, ($signed(w_a) > $signed(w_b))};
        endcase
    end

    assign w_md_req.start  = w_md_start;
    assign w_md_req.is_div = (r_act == OP_DIV);
    assign w_md_req.a      = w_a;
    assign w_md_req.b      = w_b;

    sbe_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_rsp   (w_md_rsp)
    );

    always_comb begin
        n_state        = r_state;
        n_sp           = r_sp;
        n_halted       = r_halted;
        n_tos          = r_tos;
        w_mem_we       = 1'b0;
        w_wr_addr      = w_addr_nos;
        w_wr_data      = r_tos;
        w_md_start     = 1'b0;
        w_fin          = 1'b0;
        w_fin_status   = STS_OK;
        w_fin_print    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    w_fin   = 1'b1;
                    n_state = ST_IDLE;
                    if (r_halted) begin
                        w_fin_status = STS_HALTED;
                    end else begin
                        unique case (r_act)
                            OP_CONST: begin
                                if (r_sp >= SP_W'(STACK_DEPTH)) begin
                                    w_fin_status = STS_OVERFLOW;
                                end else begin
                                    w_mem_we  = 1'b1;
                                    w_wr_addr = AW'(r_sp);
                                    w_wr_data = '{is_bool: r_cbool, payload: r_cval};
                                    n_tos     = '{is_bool: r_cbool, payload: r_cval};
                                    n_sp      = r_sp + SP_W'(1);
                                end
                            end
                            OP_RET: begin
                                n_halted = 1'b1;
                            end
                            OP_NEG: begin
                                if (w_lt1) begin
                                    w_fin_status = STS_UNDERFLOW;
                                end else begin
                                    w_mem_we  = 1'b1;
                                    w_wr_addr = w_addr_top;
                                    w_wr_data = '{is_bool: 1'b0,
                                                  payload: WORD_W'(0) - r_tos.payload};
                                    n_tos     = '{is_bool: 1'b0,
                                                  payload: WORD_W'(0) - r_tos.payload};
                                end
                            end
                            OP_POP, OP_SHOW: begin
                                if (w_lt1) begin
                                    w_fin_status = STS_UNDERFLOW;
                                end else begin
                                    w_fin_print = (r_act == OP_SHOW);
                                    n_tos       = r_rd_data;
                                    n_sp        = r_sp - SP_W'(1);
                                end
                            end
                            OP_ADD, OP_SUB, OP_GT: begin
                                if (w_lt2) begin
                                    w_fin_status = STS_UNDERFLOW;
                                end else begin
                                    w_mem_we  = 1'b1;
                                    w_wr_data = '{is_bool: (r_act == OP_GT), payload: w_alu};
                                    n_tos     = '{is_bool: (r_act == OP_GT), payload: w_alu};
                                    n_sp      = r_sp - SP_W'(1);
                                end
                            end
                            OP_MUL, OP_DIV: begin
                                if (w_lt2) begin
                                    w_fin_status = STS_UNDERFLOW;
                                end else if (r_act == OP_DIV && w_b == '0) begin
                                    w_fin_status = STS_DIVZERO;
                                end else begin
                                    w_fin      = 1'b0;
                                    w_md_start = 1'b1;
                                    n_state    = ST_WAIT;
                                end
                            end
                            default: begin
                                w_fin_status = STS_UNKNOWN;
                            end
                        endcase
                    end
                end
            end
            ST_WAIT: begin
                if (!w_md_rsp.busy && w_out_free) begin
                    w_fin     = 1'b1;
                    n_state   = ST_IDLE;
                    w_mem_we  = 1'b1;
                    w_wr_data = '{is_bool: 1'b0, payload: w_md_rsp.result};
                    n_tos     = '{is_bool: 1'b0, payload: w_md_rsp.result};
                    n_sp      = r_sp - SP_W'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sp        <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_halted <= n_halted;
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos <= n_tos;
        if (w_accept) begin
            r_act   <= s_axis_tuser[ACT_W-1:0];
            r_cval  <= s_axis_tdata[WORD_W-1:0];
            r_cbool <= s_axis_tuser[ACT_W];
        end
        if (w_fin) begin
            r_out_status <= w_fin_status;
            r_out_pvalid <= w_fin_print;
            r_out_pval   <= w_fin_print ? r_tos.payload : '0;
            r_out_pbool  <= w_fin_print && r_tos.is_bool;
            r_out_depth  <= DEPTH_OUT_W'(n_sp);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - WORD_W - DEPTH_OUT_W){1'b0}},
                            r_out_depth, r_out_pval};
    assign m_axis_tuser  = {r_out_pbool, r_out_pvalid, r_out_status};

    `SBE_ASSERT_IMPL(a_sp_bound, i_clk, i_rst_n, 1'b1, r_sp <= SP_W'(STACK_DEPTH),
                     "stack pointer beyond depth")
    `SBE_ASSERT_NEXT(a_halt_frozen, i_clk, i_rst_n, r_state == ST_EXEC && r_halted,
                     $stable(r_sp), "halted block moved the stack pointer")
    `SBE_ASSERT_IMPL(a_we_busy, i_clk, i_rst_n, w_mem_we, r_state != ST_IDLE,
                     "stack write while idle")
    `SBE_ASSERT_IMPL(a_wait_op, i_clk, i_rst_n, r_state == ST_WAIT,
                     r_act == OP_MUL || r_act == OP_DIV, "wait state without mul or div")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking bench for stack_bytecode_executor_unit: directed, random, then halting rows
// depends on sbe_pkg and the rtl top; predicts every result beat and compares it field by field
`default_nettype none

module testbench;
    import sbe_pkg::*;

    localparam int STACK_DEPTH = 256;
    localparam int NUM_RANDOM  = 480;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   print_valid;
        logic [WORD_W-1:0]      show_value;
        logic                   print_is_bool;
        logic [DEPTH_OUT_W-1:0] depth_after;
    } t_exec_result;

    typedef struct {
        logic [ACT_W-1:0]       op;
        logic [WORD_W-1:0]      cval;
        logic                   cbool;
        bit                     typed;
        logic [STATUS_W-1:0]    exp_status;
        logic [DEPTH_OUT_W-1:0] exp_depth;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [63:0] constant_value
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    // [3:0] action, [4] constant_is_bool
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [63:0] show_value, [72:64] depth_after, [79:73] zero
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // [2:0] status, [3] print_valid, [4] print_is_bool
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    stack_bytecode_executor_unit #(.STACK_DEPTH(STACK_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // shadow machine state
    t_entry      stack_model [STACK_DEPTH];
    int unsigned stack_ptr = 0;
    bit          halted = 1'b0;
    int unsigned max_depth = 0;

    t_exec_result pending_results[$];
    int  mismatches = 0;
    int  results_checked = 0;
    int  prints_checked = 0;
    int  faults_checked = 0;
    bit  hold_req = 1'b0;
    int  burst_left = 0;
    int  no_gap_left = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_exec_result execute_instr(logic [ACT_W-1:0] op,
                                                   logic [WORD_W-1:0] cval, logic cbool);
        t_exec_result res;
        logic [WORD_W-1:0] a, b, r, ua, ub, q;
        logic tag;
        res = '0;
        res.status = STS_OK;
        r = '0;
        tag = 1'b0;
        if (halted) begin
            res.status = STS_HALTED;
        end else if (op == OP_CONST) begin
            if (stack_ptr >= STACK_DEPTH) begin
                res.status = STS_OVERFLOW;
            end else begin
                stack_model[stack_ptr] = '{is_bool: cbool, payload: cval};
                stack_ptr++;
            end
        end else if (op == OP_RET) begin
            halted = 1'b1;
        end else if (op > OP_RET) begin
            res.status = STS_UNKNOWN;
        end else if (op == OP_NEG || op == OP_POP || op == OP_SHOW) begin
            if (stack_ptr < 1) begin
                res.status = STS_UNDERFLOW;
            end else if (op == OP_NEG) begin
                stack_model[stack_ptr-1] = '{is_bool: 1'b0,
                                             payload: -stack_model[stack_ptr-1].payload};
            end else begin
                if (op == OP_SHOW) begin
                    res.print_valid   = 1'b1;
                    res.show_value    = stack_model[stack_ptr-1].payload;
                    res.print_is_bool = stack_model[stack_ptr-1].is_bool;
                end
                stack_ptr--;
            end
        end else begin
            if (stack_ptr < 2) begin
                res.status = STS_UNDERFLOW;
            end else begin
                a = stack_model[stack_ptr-2].payload;
                b = stack_model[stack_ptr-1].payload;
                case (op)
                    OP_ADD: r = a + b;
                    OP_SUB: r = a - b;
                    OP_MUL: r = a * b;
                    OP_DIV: begin
                        if (b == '0) begin
                            res.status = STS_DIVZERO;
                        end else begin
                            // magnitudes keep min / -1 wrapping back to min
                            ua = a[WORD_W-1] ? -a : a;
                            ub = b[WORD_W-1] ? -b : b;
                            q = ua / ub;
                            r = (a[WORD_W-1] != b[WORD_W-1]) ? -q : q;
                        end
                    end
                    default: begin
                        r = ($signed(a) > $signed(b)) ? 64'd1 : 64'd0;
                        tag = 1'b1;
                    end
                endcase
                if (res.status == STS_OK) begin
                    stack_model[stack_ptr-2] = '{is_bool: tag, payload: r};
                    stack_ptr--;
                end
            end
        end
        if (stack_ptr > max_depth) max_depth = stack_ptr;
        res.depth_after = stack_ptr[DEPTH_OUT_W-1:0];
        return res;
    endfunction

    function automatic t_stim_row make_row(logic [ACT_W-1:0] op, logic [WORD_W-1:0] cval,
                                           logic cbool, bit typed,
                                           logic [STATUS_W-1:0] exp_status,
                                           logic [DEPTH_OUT_W-1:0] exp_depth);
        t_stim_row row;
        row.op = op;
        row.cval = cval;
        row.cbool = cbool;
        row.typed = typed;
        row.exp_status = exp_status;
        row.exp_depth = exp_depth;
        return row;
    endfunction

    function automatic logic [WORD_W-1:0] pick_operand();
        logic [WORD_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 16)) - 64'd8;
            2: begin
                case ($urandom_range(0, 4))
                    0: v = 64'd0;
                    1: v = 64'd1;
                    2: v = '1;
                    3: v = 64'h7fff_ffff_ffff_ffff;
                    default: v = 64'h8000_0000_0000_0000;
                endcase
            end
            default: v = 64'($urandom_range(0, 1));
        endcase
        return v;
    endfunction

    // well-formed most of the time; return is kept for the very end
    function automatic logic [ACT_W-1:0] choose_opcode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) return ACT_W'(OP_RET + 1 + $urandom_range(0, 5));
        if (stack_ptr < 2 && r < 60) return OP_CONST;
        if (r < 34) return OP_CONST;
        if (r < 44) return OP_ADD;
        if (r < 52) return OP_SUB;
        if (r < 60) return OP_MUL;
        if (r < 68) return OP_DIV;
        if (r < 74) return OP_NEG;
        if (r < 80) return OP_GT;
        if (r < 88) return OP_SHOW;
        if (r < 94) return OP_POP;
        return OP_CONST;
    endfunction

    task automatic issue_instr(t_stim_row row, bit last);
        t_exec_result pred;
        t_exec_result typed_res;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.cval;
        s_axis_tuser  <= {row.cbool, row.op};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = execute_instr(row.op, row.cval, row.cbool);
        if (row.typed) begin
            typed_res = '0;
            typed_res.status = row.exp_status;
            typed_res.depth_after = row.exp_depth;
            pending_results.push_back(typed_res);
        end else begin
            pending_results.push_back(pred);
        end
        if (last) begin
            s_axis_tvalid <= 1'b0;
        end else if (no_gap_left > 0) begin
            no_gap_left--;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic void check_field(string name, logic [WORD_W-1:0] exp_v,
                                        logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("ERROR at %0t: %s expected %h got %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // result side: checks every beat, stalls on its own pattern and on the source's hold request
    initial begin : result_sink
        int cyc;
        int hold_left;
        int mode;
        t_exec_result exp_res;
        cyc = 0;
        hold_left = 0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $display("ERROR at %0t: result beat with nothing pending, tdata %h tuser %h",
                             $time, m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end else begin
                    exp_res = pending_results.pop_front();
                    check_field("status", WORD_W'(exp_res.status),
                                WORD_W'(m_axis_tuser[2:0]));
                    check_field("print_valid", WORD_W'(exp_res.print_valid),
                                WORD_W'(m_axis_tuser[3]));
                    check_field("show_value", exp_res.show_value, m_axis_tdata[63:0]);
                    check_field("print_is_bool", WORD_W'(exp_res.print_is_bool),
                                WORD_W'(m_axis_tuser[4]));
                    check_field("depth_after", WORD_W'(exp_res.depth_after),
                                WORD_W'(m_axis_tdata[72:64]));
                    results_checked++;
                    if (exp_res.print_valid) prints_checked++;
                    if (exp_res.status != STS_OK) faults_checked++;
                end
            end
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (cyc % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin : run_limit
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin : instr_source
        t_stim_row dir_table[$];
        t_stim_row row;
        int tail_start;
        dir_table.push_back(make_row(OP_POP,   '0, 1'b0, 1, STS_UNDERFLOW, 9'd0));
        dir_table.push_back(make_row(OP_SHOW,  '0, 1'b0, 1, STS_UNDERFLOW, 9'd0));
        dir_table.push_back(make_row(OP_NEG,   '0, 1'b0, 1, STS_UNDERFLOW, 9'd0));
        dir_table.push_back(make_row(OP_DIV,   '0, 1'b0, 1, STS_UNDERFLOW, 9'd0));
        dir_table.push_back(make_row(OP_CONST, 64'h7fff_ffff_ffff_ffff, 1'b0, 1, STS_OK, 9'd1));
        // binary op with a single entry
        dir_table.push_back(make_row(OP_GT,    '0, 1'b0, 1, STS_UNDERFLOW, 9'd1));
        dir_table.push_back(make_row(OP_CONST, 64'd1, 1'b0, 1, STS_OK, 9'd2));
        dir_table.push_back(make_row(OP_ADD,   '0, 1'b0, 0, STS_OK, 9'd0));
        dir_table.push_back(make_row(OP_SHOW,  '0, 1'b0, 0, STS_OK, 9'd0));
        dir_table.push_back(make_row(OP_CONST, 64'h8000_0000_0000_0000, 1'b0, 1, STS_OK, 9'd1));
        dir_table.push_back(make_row(OP_CONST, '1, 1'b0, 1, STS_OK, 9'd2));
        // min / -1 wraps
        dir_table.push_back(make_row(OP_DIV,   '0, 1'b0, 0, STS_OK, 9'd0));
        dir_table.push_back(make_row(OP_CONST, 64'd0, 1'b0, 1, STS_OK, 9'd2));
        dir_table.push_back(make_row(OP_DIV,   '0, 1'b0, 1, STS_DIVZERO, 9'd2));
        dir_table.push_back(make_row(OP_POP,   '0, 1'b0, 1, STS_OK, 9'd1));
        dir_table.push_back(make_row(OP_NEG,   '0, 1'b0, 0, STS_OK, 9'd0));
        dir_table.push_back(make_row(OP_CONST, 64'd1, 1'b1, 1, STS_OK, 9'd2));
        dir_table.push_back(make_row(OP_GT,    '0, 1'b0, 0, STS_OK, 9'd0));
        dir_table.push_back(make_row(OP_SHOW,  '0, 1'b0, 0, STS_OK, 9'd0));
        dir_table.push_back(make_row(ACT_W'(10), '1, 1'b1, 1, STS_UNKNOWN, 9'd0));
        dir_table.push_back(make_row(ACT_W'(15), '0, 1'b0, 1, STS_UNKNOWN, 9'd0));
        // boolean tag on a non-boolean payload
        dir_table.push_back(make_row(OP_CONST, -64'sd5, 1'b1, 1, STS_OK, 9'd1));
        dir_table.push_back(make_row(OP_CONST, 64'd3, 1'b0, 1, STS_OK, 9'd2));
        dir_table.push_back(make_row(OP_MUL,   '0, 1'b0, 0, STS_OK, 9'd0));
        dir_table.push_back(make_row(OP_CONST, 64'd9, 1'b0, 1, STS_OK, 9'd2));
        dir_table.push_back(make_row(OP_SUB,   '0, 1'b0, 0, STS_OK, 9'd0));
        dir_table.push_back(make_row(OP_SHOW,  '0, 1'b0, 0, STS_OK, 9'd0));
        // halting rows run after the random part, since only reset clears the halt
        tail_start = dir_table.size();
        dir_table.push_back(make_row(OP_RET,   '0, 1'b0, 0, STS_OK, 9'd0));
        dir_table.push_back(make_row(OP_CONST, 64'd42, 1'b0, 0, STS_OK, 9'd0));
        dir_table.push_back(make_row(OP_SHOW,  '0, 1'b0, 0, STS_OK, 9'd0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < tail_start; i++) issue_instr(dir_table[i], 1'b0);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == 150) begin
                // long receiver hold-off while the sender keeps offering
                hold_req = 1'b1;
                no_gap_left = 80;
            end
            if (n == 240) begin
                while (stack_ptr < STACK_DEPTH)
                    issue_instr(make_row(OP_CONST, pick_operand(), 1'($urandom_range(0, 1)),
                                         0, STS_OK, 9'd0), 1'b0);
                repeat (3)
                    issue_instr(make_row(OP_CONST, pick_operand(), 1'($urandom_range(0, 1)),
                                         0, STS_OK, 9'd0), 1'b0);
                repeat (40)
                    issue_instr(make_row(choose_opcode(), pick_operand(),
                                         1'($urandom_range(0, 1)), 0, STS_OK, 9'd0), 1'b0);
            end
            row = make_row(choose_opcode(), pick_operand(), 1'($urandom_range(0, 1)),
                           0, STS_OK, 9'd0);
            issue_instr(row, 1'b0);
        end

        for (int i = tail_start; i < dir_table.size(); i++)
            issue_instr(dir_table[i], i == dir_table.size() - 1);

        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() > 0) begin
            $display("ERROR at %0t: %0d results never arrived", $time, pending_results.size());
            mismatches++;
        end

        $display("run covered %0d instruction results, %0d printed values, %0d fault reports",
                 results_checked, prints_checked, faults_checked);
        $display("stack reached depth %0d of %0d, run ended in the halted state",
                 max_depth, STACK_DEPTH);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+src
src/sbe_pkg.sv
src/sbe_muldiv.sv
src/stack_bytecode_executor_unit.sv
tb/testbench.sv
